>>> rtl/sdes_pkg.sv
// S-DES package: permutation functions, S-box tables and shared types.
// No dependencies; sdes_key_sched, sdes_round and the top level import this package.
`default_nettype none

package sdes_pkg;

  // Subkeys in the order the two rounds use them
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } sdes_subkeys_t;

  // S-box tables, indexed [row][column]; S1 row 0 column 0 holds 1
  localparam logic [1:0] SBOX0 [0:3][0:3] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };

  localparam logic [1:0] SBOX1 [0:3][0:3] = '{
    '{2'd1, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  // P10 on the raw key
  function automatic logic [9:0] perm_p10(input logic [9:0] k);
    return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
  endfunction

  // P8 selects 8 of the 10 rotated key bits
  function automatic logic [7:0] perm_p8(input logic [9:0] x);
    return {x[4], x[7], x[3], x[6], x[2], x[5], x[0], x[1]};
  endfunction

  // Initial permutation
  function automatic logic [7:0] perm_ip(input logic [7:0] b);
    return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
  endfunction

  // Inverse of the initial permutation
  function automatic logic [7:0] perm_ipinv(input logic [7:0] x);
    return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
  endfunction

  // Expansion of a half block to eight bits
  function automatic logic [7:0] perm_ep(input logic [3:0] h);
    return {h[0], h[3], h[2], h[1], h[2], h[1], h[0], h[3]};
  endfunction

  // P4 on the combined S-box outputs
  function automatic logic [3:0] perm_p4(input logic [3:0] s);
    return {s[2], s[0], s[1], s[3]};
  endfunction

  // Rotate a 5-bit half left by one
  function automatic logic [4:0] rot1(input logic [4:0] x);
    return {x[3:0], x[4]};
  endfunction

  // Rotate a 5-bit half left by two
  function automatic logic [4:0] rot2(input logic [4:0] x);
    return {x[2:0], x[4:3]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/sdes_if.sv
// Valid/ready channel interfaces for the S-DES unit: input word and result word.
// Depends on nothing; used by the top level.
`default_nettype none

interface sdes_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [9:0] cipher_key;
  logic [7:0] data_block;

  modport source (output valid, output mode, output cipher_key, output data_block,
                  input ready);
  modport sink   (input valid, input mode, input cipher_key, input data_block,
                  output ready);
endinterface

interface sdes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_block;

  modport source (output valid, output result_block, input ready);
  modport sink   (input valid, input result_block, output ready);
endinterface

`default_nettype wire

>>> rtl/sdes_key_sched.sv
// S-DES key schedule: P10, rotates and P8 to form both subkeys, ordered by mode.
// Depends on sdes_pkg.
`default_nettype none

module sdes_key_sched (
  input  wire logic                   mode_i,
  input  wire logic [9:0]             cipher_key_i,
  output sdes_pkg::sdes_subkeys_t     subkeys_o
);
  import sdes_pkg::*;

  logic [9:0] p10;
  logic [4:0] lh1, rh1, lh3, rh3;
  logic [7:0] k1, k2;

  // Derive both subkeys
  always_comb begin
    p10 = perm_p10(cipher_key_i);
    lh1 = rot1(p10[9:5]);
    rh1 = rot1(p10[4:0]);
    lh3 = rot2(lh1);
    rh3 = rot2(rh1);
    k1  = perm_p8({lh1, rh1});
    k2  = perm_p8({lh3, rh3});
  end

  // Swap the order for decryption; first subkey sits in the upper byte
  assign subkeys_o = mode_i ? {k2, k1} : {k1, k2};

endmodule

`default_nettype wire

>>> rtl/sdes_round.sv
// S-DES round function fk: expansion, subkey XOR, S0/S1 lookup, P4.
// Depends on sdes_pkg.
`default_nettype none

module sdes_round (
  input  wire logic [3:0] half_i,
  input  wire logic [7:0] subkey_i,
  output logic      [3:0] f_o
);
  import sdes_pkg::*;

  logic [7:0] x;
  logic [1:0] s0, s1;

  // Expand, mix in the subkey and substitute
  always_comb begin
    x   = perm_ep(half_i) ^ subkey_i;
    s0  = SBOX0[{x[7], x[4]}][x[6:5]];
    s1  = SBOX1[{x[3], x[0]}][x[2:1]];
    f_o = perm_p4({s0, s1});
  end

endmodule

`default_nettype wire

>>> rtl/simplified_des_block_cipher_unit.sv
// S-DES block cipher unit top level: input register, key schedule, two rounds,
// result register. Depends on sdes_pkg, sdes_if, sdes_key_sched, sdes_round.
//
//   channel  dir  payload                              word accepted when
//   in_i     in   mode, cipher_key[9:0], data_block[7:0] in_i.valid && in_i.ready
//   out_o    out  result_block[7:0]                    out_o.valid && out_o.ready
//
// One word per cycle sustained while out_o.ready stays high; an accepted input word
// is held in the input register, then moves to the result register to be presented.
// The input register feeds the key schedule and both rounds combinationally and
// the result register holds the output word. When the result is stalled the
// input register still takes one more word; input ready drops only when both
// registers are full. rst_ni clears the valid flags only; the data registers are not reset.
`default_nettype none

module simplified_des_block_cipher_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdes_in_if.sink   in_i,
  sdes_out_if.source out_o
);
  import sdes_pkg::*;

  logic          in_vld_q;
  logic          mode_q;
  logic [9:0]    key_q;
  logic [7:0]    blk_q;
  logic          out_vld_q;
  logic [7:0]    res_q;
  logic          advance;
  logic          in_rdy;

  sdes_subkeys_t subkeys;
  logic [7:0]    ip;
  logic [3:0]    f1, f2;
  logic [3:0]    r1, l2;
  logic [7:0]    res_d;

  // Handshake control
  assign advance     = !out_vld_q || out_o.ready;
  assign in_rdy      = !in_vld_q || advance;
  assign in_i.ready  = in_rdy;
  assign out_o.valid = out_vld_q;
  assign out_o.result_block = res_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_rdy) begin
      mode_q <= in_i.mode;
      key_q  <= in_i.cipher_key;
      blk_q  <= in_i.data_block;
    end
  end

  sdes_key_sched u_key_sched (
    .mode_i       (mode_q),
    .cipher_key_i (key_q),
    .subkeys_o    (subkeys)
  );

  assign ip = perm_ip(blk_q);

  // First round on the right half, then swap
  sdes_round u_round1 (
    .half_i   (ip[3:0]),
    .subkey_i (subkeys.first),
    .f_o      (f1)
  );

  assign r1 = ip[7:4] ^ f1;

  sdes_round u_round2 (
    .half_i   (r1),
    .subkey_i (subkeys.second),
    .f_o      (f2)
  );

  assign l2    = ip[3:0] ^ f2;
  assign res_d = perm_ipinv({l2, r1});

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for simplified_des_block_cipher_unit: directed table, then random words.
// Depends on rtl/sdes_pkg.sv, rtl/sdes_if.sv and the unit itself.
// Expected blocks come from a bit-level S-DES predictor unless a golden value is typed in.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam int NUM_RANDOM   = 750;
  localparam int NUM_DIRECTED = 16;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLDOFF_LEN  = 64;

  // Bit selection tables, four bits per entry, leftmost entry first
  localparam logic [39:0] P10_SEL   = {4'd2, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd0, 4'd8, 4'd7,
                                       4'd5};
  localparam logic [31:0] P8_SEL    = {4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8};
  localparam logic [31:0] IP_SEL    = {4'd1, 4'd5, 4'd2, 4'd0, 4'd3, 4'd7, 4'd4, 4'd6};
  localparam logic [31:0] IPINV_SEL = {4'd3, 4'd0, 4'd2, 4'd4, 4'd6, 4'd1, 4'd7, 4'd5};
  localparam logic [31:0] EP_SEL    = {4'd3, 4'd0, 4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd0};
  localparam logic [15:0] P4_SEL    = {4'd1, 4'd3, 4'd2, 4'd0};

  // Substitution boxes, row-major, entry (0,0) in the top two bits
  localparam logic [31:0] S0_BOX = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                    2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  // Entry (0,0) of the second box is 1, not the textbook 0
  localparam logic [31:0] S1_BOX = {2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                    2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  typedef struct packed {
    logic       dec;
    logic [9:0] key;
    logic [7:0] blk;
    logic       known;
    logic [7:0] golden;
  } cipher_vec_t;

  // Directed words; golden is typed in only for three of the all-zero key cases
  localparam cipher_vec_t DIRECTED_VECS [NUM_DIRECTED] = '{
    {MODE_ENC, 10'h000, 8'h00, 1'b1, 8'hB1},
    {MODE_DEC, 10'h000, 8'h00, 1'b1, 8'hB1},
    {MODE_DEC, 10'h000, 8'hB1, 1'b1, 8'h00},
    {MODE_ENC, 10'h000, 8'hFF, 1'b0, 8'h00},
    {MODE_ENC, 10'h3FF, 8'h00, 1'b0, 8'h00},
    {MODE_ENC, 10'h3FF, 8'hFF, 1'b0, 8'h00},
    {MODE_DEC, 10'h3FF, 8'hFF, 1'b0, 8'h00},
    {MODE_DEC, 10'h3FF, 8'h00, 1'b0, 8'h00},
    {MODE_ENC, 10'h282, 8'h97, 1'b0, 8'h00},
    {MODE_DEC, 10'h282, 8'h97, 1'b0, 8'h00},
    {MODE_ENC, 10'h155, 8'hAA, 1'b0, 8'h00},
    {MODE_DEC, 10'h2AA, 8'h55, 1'b0, 8'h00},
    {MODE_ENC, 10'h200, 8'h80, 1'b0, 8'h00},
    {MODE_ENC, 10'h001, 8'h01, 1'b0, 8'h00},
    {MODE_DEC, 10'h001, 8'h80, 1'b0, 8'h00},
    {MODE_ENC, 10'h3FF, 8'h01, 1'b0, 8'h00}
  };

  logic clk;
  logic rst_n;

  logic [7:0] expected_blocks [$];
  int         words_sent;
  int         decrypt_words;
  int         results_checked;
  int         error_count;

  sdes_in_if  in_bus ();
  sdes_out_if out_bus ();

  simplified_des_block_cipher_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Build a word from selected source bits, leftmost selection first
  function automatic logic [9:0] gather_bits(input logic [9:0] src, input int width,
                                             input int count, input logic [39:0] sel);
    logic [9:0] acc;
    int         idx;
    int         pos;
    acc = '0;
    for (idx = 0; idx < count; idx++) begin
      pos = int'(sel[4*(count-1-idx) +: 4]);
      acc = {acc[8:0], src[width-1-pos]};
    end
    return acc;
  endfunction

  function automatic logic [4:0] rotl5(input logic [4:0] x);
    return {x[3:0], x[4]};
  endfunction

  // Row from the outer nibble bits, column from the inner ones
  function automatic logic [1:0] sbox_out(input logic [31:0] box, input logic [3:0] nib);
    logic [3:0] entry;
    entry = {nib[3], nib[0], nib[2:1]};
    return box[2*(15-entry) +: 2];
  endfunction

  function automatic logic [3:0] mix_half(input logic [3:0] half, input logic [7:0] subkey);
    logic [9:0] t;
    logic [7:0] x;
    logic [3:0] s;
    t = gather_bits({6'b0, half}, 4, 8, {8'b0, EP_SEL});
    x = t[7:0] ^ subkey;
    s = {sbox_out(S0_BOX, x[7:4]), sbox_out(S1_BOX, x[3:0])};
    t = gather_bits({6'b0, s}, 4, 4, {24'b0, P4_SEL});
    return t[3:0];
  endfunction

  function automatic logic [7:0] sdes_transform(input logic dec, input logic [9:0] key,
                                                input logic [7:0] blk);
    logic [9:0] t;
    logic [4:0] kl;
    logic [4:0] kr;
    logic [7:0] k1;
    logic [7:0] k2;
    logic [7:0] ka;
    logic [7:0] kb;
    logic [3:0] lh;
    logic [3:0] rh;
    logic [3:0] r1;
    logic [3:0] l2;
    // Derive both subkeys
    t  = gather_bits(key, 10, 10, P10_SEL);
    kl = rotl5(t[9:5]);
    kr = rotl5(t[4:0]);
    t  = gather_bits({kl, kr}, 10, 8, {8'b0, P8_SEL});
    k1 = t[7:0];
    kl = rotl5(rotl5(kl));
    kr = rotl5(rotl5(kr));
    t  = gather_bits({kl, kr}, 10, 8, {8'b0, P8_SEL});
    k2 = t[7:0];
    ka = (dec == MODE_DEC) ? k2 : k1;
    kb = (dec == MODE_DEC) ? k1 : k2;
    // Two Feistel rounds between IP and its inverse
    t  = gather_bits({2'b0, blk}, 8, 8, {8'b0, IP_SEL});
    lh = t[7:4];
    rh = t[3:0];
    r1 = lh ^ mix_half(rh, ka);
    l2 = rh ^ mix_half(r1, kb);
    t  = gather_bits({2'b0, l2, r1}, 8, 8, {8'b0, IPINV_SEL});
    return t[7:0];
  endfunction

  // Offer one word after a random gap; record its expected block on acceptance
  task automatic send_word(input logic dec, input logic [9:0] key, input logic [7:0] blk,
                           input logic known, input logic [7:0] golden);
    int gap;
    gap = (((words_sent / 40) % 4) == 1) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= dec;
    in_bus.cipher_key <= key;
    in_bus.data_block <= blk;
    do @(posedge clk); while (!in_bus.ready);
    expected_blocks.push_back(known ? golden : sdes_transform(dec, key, blk));
    words_sent++;
    if (dec == MODE_DEC) decrypt_words++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stimulus: reset, directed table, random words, drain
  initial begin
    cipher_vec_t vec;
    logic [9:0]  key;
    logic [7:0]  blk;
    int          i;
    words_sent        = 0;
    decrypt_words     = 0;
    error_count       = 0;
    rst_n             = 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.mode       <= MODE_ENC;
    in_bus.cipher_key <= '0;
    in_bus.data_block <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) begin
      vec = DIRECTED_VECS[i];
      send_word(vec.dec, vec.key, vec.blk, vec.known, vec.golden);
    end

    // Mostly uniform keys and blocks, with the odd all-zero or all-one value
    for (i = 0; i < NUM_RANDOM; i++) begin
      key = 10'($urandom_range(0, 1023));
      blk = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) key = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
      if ($urandom_range(0, 15) == 0) blk = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      send_word(logic'($urandom_range(0, 1)), key, blk, 1'b0, 8'h00);
    end
    in_bus.valid <= 1'b0;

    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words (%0d decrypt, %0d directed) under random gaps and stalls",
             words_sent, decrypt_words, NUM_DIRECTED);
    $display("%0d result words compared, %0d errors", results_checked, error_count);
    if (error_count == 0) begin
      $display("simplified_des_block_cipher_unit test passed");
    end else begin
      $display("simplified_des_block_cipher_unit test failed");
    end
    $finish;
  end

  // Result side: random stalls, two long hold-offs, compare against oldest expectation
  initial begin
    int         stall;
    logic [7:0] want;
    results_checked = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = (((results_checked / 64) % 3) == 1) ? 0 : $urandom_range(0, 7);
      if (results_checked == 150 || results_checked == 500) stall = HOLDOFF_LEN;
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      results_checked++;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual result_block=%02h",
                 $time, out_bus.result_block);
        error_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (out_bus.result_block !== want) begin
          $display("%0t: result_block mismatch, expected %02h, actual %02h",
                   $time, want, out_bus.result_block);
          error_count++;
        end
      end
    end
  end

  // Hard stop if the handshakes hang
  initial begin
    #500_000;
    $display("Timeout with %0d expected result words outstanding", expected_blocks.size());
    $display("simplified_des_block_cipher_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/sdes_pkg.sv
rtl/sdes_if.sv
rtl/sdes_key_sched.sv
rtl/sdes_round.sv
rtl/simplified_des_block_cipher_unit.sv
tb/tb_top.sv
